[hdl/masked_sprite_dither_compositor_unit_macros.svh]
// Assertion helpers for the sprite dither compositor.
// Both forms sample on aclk and are disabled while aresetn is low.
`ifndef MASKED_SPRITE_DITHER_COMPOSITOR_UNIT_MACROS_SVH
`define MASKED_SPRITE_DITHER_COMPOSITOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MSDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSDC_ASSERT_IMP(lbl, ante, cons, msg)
`define MSDC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/msdc_pkg.sv]
package msdc_pkg;

    localparam int COL_W = 10;
    localparam int ERR_W = 9;
    localparam int SCREEN_WIDTH  = 400;
    localparam int SCREEN_HEIGHT = 300;

    typedef enum logic [2:0] {
        MODE_DIFFUSE  = 3'd0,
        MODE_THRESH   = 3'd1,
        MODE_BAYER4   = 3'd2,
        MODE_BAYER8   = 3'd3,
        MODE_HYB_SOFT = 3'd4,
        MODE_HYB_INK  = 3'd5
    } dither_mode_t;

    typedef enum logic [2:0] {
        REG_DITHER_MODE  = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_X_OFFSET     = 3'd3,
        REG_Y_OFFSET     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]        dither_mode;
        logic [COL_W-1:0]  image_width;
        logic [COL_W-1:0]  image_height;
        logic [10:0]       x_offset;
        logic [10:0]       y_offset;
    } cfg_t;

    // error line write requests from the pixel core
    typedef struct packed {
        logic              clear;
        logic              w1_en;
        logic [COL_W-1:0]  w1_addr;
        logic [ERR_W-1:0]  w1_data;
        logic              w2_en;
        logic [COL_W-1:0]  w2_addr;
        logic [ERR_W-1:0]  w2_data;
    } err_wr_t;

    typedef struct packed {
        logic        emit;
        logic [8:0]  screen_col;
        logic [8:0]  screen_row;
        logic        ink;
    } res_t;

    localparam logic [7:0] ORD4 [16] = '{
          8, 136,  40, 168,
        200,  72, 232, 104,
         56, 184,  24, 152,
        248, 120, 216,  88
    };

    localparam logic [7:0] ORD8 [64] = '{
          2, 130,  34, 162,  10, 138,  42, 170,
        194,  66, 226,  98, 202,  74, 234, 106,
         50, 178,  18, 146,  58, 186,  26, 154,
        242, 114, 210,  82, 250, 122, 218,  90,
         14, 142,  46, 174,   6, 134,  38, 166,
        206,  78, 238, 110, 198,  70, 230, 102,
         62, 190,  30, 158,  54, 182,  22, 150,
        254, 126, 222,  94, 246, 118, 214,  86
    };

    // ordered / threshold decision, indexed by source column and row
    function automatic logic ordered_black(input logic [7:0] g, input logic [2:0] mode,
                                           input logic [2:0] c, input logic [2:0] r);
        logic [7:0] t4;
        logic [7:0] t8;
        logic       b;
        t4 = ORD4[{r[1:0], c[1:0]}];
        t8 = ORD8[{r, c}];
        unique case (mode)
            MODE_BAYER4:   b = (g <= t4);
            MODE_BAYER8:   b = (g <= t8);
            MODE_HYB_SOFT: b = (g < 8'd80)  ? 1'b1 : ((g > 8'd200) ? 1'b0 : (g <= t8));
            MODE_HYB_INK:  b = (g < 8'd100) ? 1'b1 : ((g > 8'd220) ? 1'b0 : (g <= t8));
            default:       b = (g < 8'd128);
        endcase
        return b;
    endfunction

    // divide by 16, rounding toward zero
    function automatic logic signed [11:0] div16_tz(input logic signed [11:0] x);
        logic signed [11:0] t;
        t = x[11] ? (x + 12'sd15) : x;
        return t >>> 4;
    endfunction

endpackage

[hdl/msdc_cfg_regs.sv]
module msdc_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [10:0]         cfg_data,
    output logic                cfg_ready,
    output msdc_pkg::cfg_t      cfg
);
    import msdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DITHER_MODE:  cfg_next.dither_mode  = cfg_data[2:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[COL_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[COL_W-1:0];
                REG_X_OFFSET:     cfg_next.x_offset     = cfg_data;
                REG_Y_OFFSET:     cfg_next.y_offset     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dither_mode  <= MODE_HYB_INK;
            cfg_reg.image_width  <= 10'd220;
            cfg_reg.image_height <= 10'd320;
            cfg_reg.x_offset     <= '0;
            cfg_reg.y_offset     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/msdc_err_line.sv]
module msdc_err_line #(
    parameter int LINE_WIDTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_load,
    input  logic [msdc_pkg::COL_W-1:0]    rd_addr,
    input  msdc_pkg::err_wr_t             wr,
    output logic [msdc_pkg::ERR_W-1:0]    err_val
);
    import msdc_pkg::*;

    localparam int AW = $clog2(LINE_WIDTH);

    logic [ERR_W-1:0]      mem [LINE_WIDTH];
    logic [ERR_W-1:0]      rd_data_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic [AW-1:0]         rd_now;
    logic                  fwd_hit_reg;
    logic [ERR_W-1:0]      fwd_data_reg;

    // pending end-of-row write (second write of a last-column pixel)
    logic                  p_valid_reg, p_valid_next;
    logic [AW-1:0]         p_addr_reg, p_addr_next;
    logic [ERR_W-1:0]      p_data_reg, p_data_next;

    logic [LINE_WIDTH-1:0] valid_reg, valid_next;

    logic                  p_commit;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [ERR_W-1:0]      wdata;

    assign rd_now   = rd_load ? rd_addr[AW-1:0] : rd_addr_reg;
    assign p_commit = p_valid_reg && !wr.w1_en && !wr.clear;
    assign we       = wr.w1_en || p_commit;
    assign waddr    = wr.w1_en ? wr.w1_addr[AW-1:0] : p_addr_reg;
    assign wdata    = wr.w1_en ? wr.w1_data : p_data_reg;

    always_comb begin
        p_valid_next = p_valid_reg;
        p_addr_next  = p_addr_reg;
        p_data_next  = p_data_reg;
        if (p_commit || wr.clear) begin
            p_valid_next = 1'b0;
        end
        if (wr.w2_en) begin
            p_valid_next = 1'b1;
            p_addr_next  = wr.w2_addr[AW-1:0];
            p_data_next  = wr.w2_data;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr.clear) begin
            valid_next = '0;
        end
        if (we) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_now];
    end

    always_ff @(posedge aclk) begin
        fwd_hit_reg  <= we && (waddr == rd_now);
        fwd_data_reg <= wdata;
        p_addr_reg   <= p_addr_next;
        p_data_reg   <= p_data_next;
        if (rd_load) begin
            rd_addr_reg <= rd_addr[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            p_valid_reg <= p_valid_next;
            valid_reg   <= valid_next;
        end
    end

    always_comb begin
        if (p_valid_reg && (p_addr_reg == rd_addr_reg)) begin
            err_val = p_data_reg;
        end else if (valid_reg[rd_addr_reg]) begin
            err_val = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        end else begin
            err_val = '0;
        end
    end

endmodule

[hdl/msdc_dither_core.sv]
module msdc_dither_core #(
    parameter int LINE_WIDTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic [7:0]                    gray,
    input  logic                          image_start,
    input  msdc_pkg::cfg_t                cfg,
    input  logic [msdc_pkg::ERR_W-1:0]    err_val,
    output logic [msdc_pkg::COL_W-1:0]    col_state,
    output logic [msdc_pkg::COL_W-1:0]    col_after,
    output msdc_pkg::res_t                res,
    output msdc_pkg::err_wr_t             wr
);
    import msdc_pkg::*;

    localparam logic [COL_W:0] LINE_LIM = (COL_W+1)'(LINE_WIDTH);

    logic [COL_W-1:0]        col_reg, col_next, row_reg, row_next;
    logic signed [ERR_W-1:0] rc_reg, rc_next, dc0_reg, dc0_next, dc1_reg, dc1_next;

    logic [COL_W-1:0]        col0, row0, w, h;
    logic signed [ERR_W-1:0] rc0, dc0_0, dc1_0, err_in, e, e_used;
    logic                    skip_all, wrap, active, fs_ok, last_col;
    logic signed [11:0]      sx, sy, ex, q3, q5, q7, q1;
    logic                    on_screen, visible, black_fs;
    logic signed [10:0]      v;
    logic [7:0]              v_cl;

    assign w = cfg.image_width;
    assign h = cfg.image_height;

    always_comb begin
        col0  = image_start ? '0 : col_reg;
        row0  = image_start ? '0 : row_reg;
        rc0   = image_start ? '0 : rc_reg;
        dc0_0 = image_start ? '0 : dc0_reg;
        dc1_0 = image_start ? '0 : dc1_reg;

        skip_all = (w == '0) || (h == '0) || (row0 >= h);
        wrap     = !skip_all && (col0 >= w);
        active   = !skip_all && !wrap;
        fs_ok    = (cfg.dither_mode == MODE_DIFFUSE) && ({1'b0, w} <= LINE_LIM);
        last_col = ({1'b0, col0} + 11'd1) >= {1'b0, w};
        err_in   = (image_start || !fs_ok) ? '0 : $signed(err_val);

        sx = {cfg.x_offset[10], cfg.x_offset} + $signed({2'b00, col0});
        sy = {cfg.y_offset[10], cfg.y_offset} + $signed({2'b00, row0});
        on_screen = !sx[11] && (sx[10:0] < 11'(SCREEN_WIDTH))
                 && !sy[11] && (sy[10:0] < 11'(SCREEN_HEIGHT));
        visible = (gray != 8'hFF) && on_screen;

        // diffusion: value, clamp, error
        v = $signed({3'b000, gray}) + {{2{err_in[ERR_W-1]}}, err_in}
          + {{2{rc0[ERR_W-1]}}, rc0};
        if (v < 0) begin
            v_cl = 8'd0;
        end else if (v > 11'sd254) begin
            v_cl = 8'd254;
        end else begin
            v_cl = v[7:0];
        end
        black_fs = v_cl < 8'd128;
        e = black_fs ? $signed({1'b0, v_cl}) : ($signed({1'b0, v_cl}) - 9'sd254);
        e_used = (active && fs_ok && visible) ? e : '0;

        ex = {{3{e_used[ERR_W-1]}}, e_used};
        q1 = div16_tz(ex);
        q3 = div16_tz((ex <<< 1) + ex);
        q5 = div16_tz((ex <<< 2) + ex);
        q7 = div16_tz((ex <<< 3) - ex);
    end

    always_comb begin
        col_next = col0;
        row_next = row0;
        rc_next  = rc0;
        dc0_next = dc0_0;
        dc1_next = dc1_0;
        priority if (skip_all) begin
            col_next = col0;
        end else if (wrap) begin
            col_next = '0;
            row_next = row0 + 10'd1;
            rc_next  = '0;
            dc0_next = '0;
            dc1_next = '0;
        end else begin
            if (fs_ok) begin
                dc0_next = dc1_0 + q5[ERR_W-1:0];
                dc1_next = q1[ERR_W-1:0];
                rc_next  = q7[ERR_W-1:0];
            end
            if (last_col) begin
                col_next = '0;
                row_next = row0 + 10'd1;
                rc_next  = '0;
                dc0_next = '0;
                dc1_next = '0;
            end else begin
                col_next = col0 + 10'd1;
            end
        end
    end

    always_comb begin
        res.emit = active && visible && ((cfg.dither_mode == MODE_DIFFUSE) ? fs_ok : 1'b1);
        res.screen_col = sx[8:0];
        res.screen_row = sy[8:0];
        res.ink = (cfg.dither_mode == MODE_DIFFUSE) ? black_fs
                : ordered_black(gray, cfg.dither_mode, col0[2:0], row0[2:0]);

        wr.clear   = fire && image_start;
        wr.w1_en   = fire && active && fs_ok && (col0 != '0);
        wr.w1_addr = col0 - 10'd1;
        wr.w1_data = dc0_0 + q3[ERR_W-1:0];
        wr.w2_en   = fire && active && fs_ok && last_col;
        wr.w2_addr = col0;
        wr.w2_data = dc1_0 + q5[ERR_W-1:0];
    end

    assign col_state = col_reg;
    assign col_after = col_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            rc_reg  <= '0;
            dc0_reg <= '0;
            dc1_reg <= '0;
        end else if (fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
            rc_reg  <= rc_next;
            dc0_reg <= dc0_next;
            dc1_reg <= dc1_next;
        end
    end

endmodule

[hdl/masked_sprite_dither_compositor_unit.sv]
// Masked sprite dither compositor. Gray sprite pixels enter on the s_ stream in
// raster order, one word per pixel; s_tuser high marks the first pixel of a sprite
// and restarts position and error state. Gray 255 is transparent. Each visible,
// on-screen pixel of the sprite gives one m_ word with its screen column, row and
// ink bit (1 black, 0 white), unless diffusing wider than LINE_WIDTH; other pixels
// give nothing. Sustained rate is one pixel per clock unless stalled: a pixel sits
// in the input register, where its dither decision and error carries are worked
// out, and its result is held in the output register. The next-row error line is
// a LINE_WIDTH x 9 memory with a registered read, issued as the pixel is accepted;
// per-entry valid flops clear it at sprite start, so there is no clearing pass.
// Configuration writes (cfg_*) are always ready and are to be made while idle.
`include "masked_sprite_dither_compositor_unit_macros.svh"

module masked_sprite_dither_compositor_unit #(
    parameter int LINE_WIDTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input pixels
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] gray
    input  logic         s_tuser,    // [0] image_start
    // pixel writes
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,    // [8:0] screen_col, [17:9] screen_row, [18] ink
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [10:0]  cfg_data
);
    import msdc_pkg::*;

    cfg_t             cfg;
    err_wr_t          err_wr;
    res_t             core_res;
    logic [ERR_W-1:0] err_val;
    logic [COL_W-1:0] col_state, col_after, rd_addr;

    logic             in_valid_reg;
    logic [7:0]       in_gray_reg;
    logic             in_start_reg;
    logic             s_accept, proc_fire;

    logic             m_valid_reg;
    logic [18:0]      m_data_reg;

    msdc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    // pixel in the input register moves on when the result slot is free or draining
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_accept  = s_tvalid && s_tready;

    // column of the incoming pixel: state after the pixel now being finished
    assign rd_addr = s_tuser ? '0 : (proc_fire ? col_after : col_state);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_gray_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    msdc_err_line #(.LINE_WIDTH(LINE_WIDTH)) u_err_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_load (s_accept),
        .rd_addr (rd_addr),
        .wr      (err_wr),
        .err_val (err_val)
    );

    msdc_dither_core #(.LINE_WIDTH(LINE_WIDTH)) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (proc_fire),
        .gray        (in_gray_reg),
        .image_start (in_start_reg),
        .cfg         (cfg),
        .err_val     (err_val),
        .col_state   (col_state),
        .col_after   (col_after),
        .res         (core_res),
        .wr          (err_wr)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            m_valid_reg <= core_res.emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            m_data_reg <= {core_res.ink, core_res.screen_row, core_res.screen_col};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};

    // a held pixel is never dropped while the result side stalls
    `MSDC_ASSERT_NXT(a_hold_pixel, in_valid_reg && !proc_fire, in_valid_reg, "pixel lost")
    // an accepted word always lands in the input register
    `MSDC_ASSERT_NXT(a_accept_lands, s_accept, in_valid_reg, "accepted word not held")
    // a drained result with nothing behind it leaves the output empty
    `MSDC_ASSERT_NXT(a_no_dup, m_tvalid && m_tready && !proc_fire, !m_tvalid,
                     "result repeated")
    // an emitting pixel always shows up on the output
    `MSDC_ASSERT_NXT(a_emit_shows, proc_fire && core_res.emit, m_tvalid, "result lost")

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import msdc_pkg::*;

    localparam int LINE_WIDTH    = 256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 60;
    localparam int DRAIN_CYCLES  = 8;     // wait for the input and output registers to empty, with margin
    localparam int HOLD_CYCLES   = 250;   // long receiver hold-off to back the block up

    // one screen write as it leaves the block
    typedef struct packed {
        logic [8:0] col;
        logic [8:0] row;
        logic       ink;
    } screen_write_t;

    // one pixel word waiting to be sent
    typedef struct packed {
        logic [7:0] gray;
        logic       sprite_start;
    } pixel_word_t;

    // ordered dither thresholds, indexed {row, col} by source position
    localparam logic [7:0] BAYER4_THR [16] = '{
          8, 136,  40, 168,
        200,  72, 232, 104,
         56, 184,  24, 152,
        248, 120, 216,  88
    };
    localparam logic [7:0] BAYER8_THR [64] = '{
          2, 130,  34, 162,  10, 138,  42, 170,
        194,  66, 226,  98, 202,  74, 234, 106,
         50, 178,  18, 146,  58, 186,  26, 154,
        242, 114, 210,  82, 250, 122, 218,  90,
         14, 142,  46, 174,   6, 134,  38, 166,
        206,  78, 238, 110, 198,  70, 230, 102,
         62, 190,  30, 158,  54, 182,  22, 150,
        254, 126, 222,  94, 246, 118, 214,  86
    };

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;     // [7:0] gray
    logic         s_tuser   = 1'b0;   // [0] image_start
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [23:0]  m_tdata;            // [8:0] screen_col, [17:9] screen_row, [18] ink
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [10:0]  cfg_data  = '0;

    masked_sprite_dither_compositor_unit #(
        .LINE_WIDTH (LINE_WIDTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Dither predictor: own copy of the registers and of the position and
    // error state, advanced once per accepted pixel word.
    // ------------------------------------------------------------------
    logic [2:0]         mdl_mode;
    logic [9:0]         mdl_width;
    logic [9:0]         mdl_height;
    logic signed [10:0] mdl_xoff;
    logic signed [10:0] mdl_yoff;
    logic [9:0]         pos_col;
    logic [9:0]         pos_row;
    logic signed [8:0]  err_line [LINE_WIDTH];   // error owed to the next row
    logic signed [8:0]  carry_right;
    logic signed [8:0]  carry_diag [2];

    screen_write_t pending_writes[$];   // predicted writes, oldest first
    pixel_word_t   pixel_q[$];          // words not yet offered to the block

    int  mismatches = 0;
    int  cycles     = 0;
    bit  sender_calm   = 1'b0;          // no gaps on the sender side
    bit  receiver_calm = 1'b0;          // no stalls on the receiver side
    bit  hold_armed    = 1'b0;          // request one long hold-off
    bit  hold_done     = 1'b0;
    bit  hold_off      = 1'b0;
    int  hold_left     = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;

    task automatic clear_carries();
        carry_right   = '0;
        carry_diag[0] = '0;
        carry_diag[1] = '0;
    endtask

    function automatic bit ordered_ink(logic [7:0] g, logic [2:0] mode, int c, int r);
        logic [7:0] t8;
        t8 = BAYER8_THR[(r % 8) * 8 + (c % 8)];
        case (mode)
            MODE_BAYER4:   return g <= BAYER4_THR[(r % 4) * 4 + (c % 4)];
            MODE_BAYER8:   return g <= t8;
            // hard black below the low knee, hard white above the high knee
            MODE_HYB_SOFT: return g < 80 || (g <= 200 && g <= t8);
            MODE_HYB_INK:  return g < 100 || (g <= 220 && g <= t8);
            default:       return g < 128;  // also the two unused mode codes
        endcase
    endfunction

    task automatic dither_pixel(input logic [7:0] g, input logic start);
        int col, row, sx, sy, v, e;
        bit fs_ok, ink, emit;
        e    = 0;
        ink  = 1'b0;
        emit = 1'b0;
        if (start) begin
            pos_col = '0;
            pos_row = '0;
            for (int i = 0; i < LINE_WIDTH; i++) err_line[i] = '0;
            clear_carries();
        end
        // zero-sized sprite or sprite already done: word is dropped
        if (mdl_width == 0 || mdl_height == 0 || pos_row >= mdl_height) return;
        // width shrunk under the current column: skip to the next row
        if (pos_col >= mdl_width) begin
            pos_col = '0;
            pos_row = pos_row + 1'b1;
            clear_carries();
            return;
        end
        col   = pos_col;
        row   = pos_row;
        fs_ok = (mdl_mode == MODE_DIFFUSE) && (mdl_width <= LINE_WIDTH);
        sx    = mdl_xoff;
        sx    = sx + col;
        sy    = mdl_yoff;
        sy    = sy + row;

        if (g != 8'hFF && sx >= 0 && sx < SCREEN_WIDTH && sy >= 0 && sy < SCREEN_HEIGHT) begin
            if (mdl_mode != MODE_DIFFUSE) begin
                ink  = ordered_ink(g, mdl_mode, col, row);
                emit = 1'b1;
            end else if (fs_ok) begin
                v = int'(g) + int'(err_line[col]) + int'(carry_right);
                if (v < 0)   v = 0;
                if (v > 254) v = 254;
                ink  = v < 128;
                e    = ink ? v : v - 254;
                emit = 1'b1;
            end
        end
        if (emit) pending_writes.push_back(screen_write_t'{sx[8:0], sy[8:0], ink});

        // transparent / off-screen pixels still shift the carries, with zero error
        if (fs_ok) begin
            if (col > 0) err_line[col - 1] = 9'(int'(carry_diag[0]) + e * 3 / 16);
            carry_diag[0] = 9'(int'(carry_diag[1]) + e * 5 / 16);
            carry_diag[1] = 9'(e / 16);
            carry_right   = 9'(e * 7 / 16);
            if (col + 1 >= mdl_width) err_line[col] = carry_diag[0];
        end

        pos_col = 10'(col + 1);
        if (pos_col >= mdl_width) begin
            pos_col = '0;
            pos_row = 10'(row + 1);
            clear_carries();
        end
    endtask

    function automatic int draw_pause(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom % 100;
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued pixel words; the predictor runs on each
    // accepted word, with the values that were on the bus at that edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pixel_driver
        pixel_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) dither_pixel(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    nxt = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.gray;
                    s_tuser  <= nxt.sprite_start;
                    send_gap <= draw_pause(sender_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted write against the oldest prediction
    // and drives a randomly stalling m_tready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : write_monitor
        screen_write_t got, want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = screen_write_t'{m_tdata[8:0], m_tdata[17:9], m_tdata[18]};
                if (pending_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: write with none pending: col %0d row %0d ink %0d",
                                 $time, got.col, got.row, got.ink);
                end else begin
                    want = pending_writes.pop_front();
                    if (got.col !== want.col || got.row !== want.row
                        || got.ink !== want.ink) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: write mismatch: want col %0d row %0d ink %0d, ",
                                      "got col %0d row %0d ink %0d"},
                                     $time, want.col, want.row, want.ink,
                                     got.col, got.row, got.ink);
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left <= draw_pause(receiver_calm);
            end
        end
    end

    // one long receiver hold-off, started on a pixel acceptance once armed,
    // so the sender keeps pushing into a backed-up block
    always @(posedge aclk) begin : receiver_hold
        if (!aresetn) begin
            hold_off  <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            hold_off  <= hold_left > 1;
        end else if (hold_armed && !hold_done && s_tvalid && s_tready) begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes pending",
                     cycles, pending_writes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DITHER_MODE:  mdl_mode   = val[2:0];
            REG_IMAGE_WIDTH:  mdl_width  = val[9:0];
            REG_IMAGE_HEIGHT: mdl_height = val[9:0];
            REG_X_OFFSET:     mdl_xoff   = val;
            REG_Y_OFFSET:     mdl_yoff   = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input logic [2:0] mode, input int w, input int h,
                             input int xo, input int yo);
        write_reg(REG_DITHER_MODE,  11'(mode));
        write_reg(REG_IMAGE_WIDTH,  11'(w));
        write_reg(REG_IMAGE_HEIGHT, 11'(h));
        write_reg(REG_X_OFFSET,     11'(xo));
        write_reg(REG_Y_OFFSET,     11'(yo));
    endtask

    // all words sent, all writes seen, and the pipe given time to empty;
    // checked again after the drain since the last word may go out late
    task automatic wait_idle();
        do begin
            while (pixel_q.size() != 0 || s_tvalid || pending_writes.size() != 0)
                @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end while (pixel_q.size() != 0 || s_tvalid || pending_writes.size() != 0);
    endtask

    task automatic push_pixel(input logic [7:0] g, input logic start);
        pixel_q.push_back(pixel_word_t'{g, start});
    endtask

    function automatic logic [7:0] draw_gray();
        case ($urandom % 8)
            0: return 8'hFF;                                 // transparent
            1: return 8'h00;
            2: return 8'd254;
            3: return 8'($urandom_range(76, 104));           // lower hybrid knees
            4: return 8'($urandom_range(124, 132) + ($urandom % 2) * 72); // 128, upper soft-mode knee
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int draw_offset(int far_edge);
        case ($urandom % 8)
            0: return -1024;
            1: return 1023;
            2: return far_edge - int'($urandom_range(0, 30)); // runs off the far edge
            3: return -int'($urandom_range(1, 20));           // starts off the near edge
            4: return int'($urandom_range(0, 2047)) - 1024;
            default: return int'($urandom_range(0, 60));
        endcase
    endfunction

    // one phase: reprogram while idle, then queue n pixels; fresh starts a new sprite,
    // otherwise the sprite in progress continues under the new settings
    task automatic sprite_phase(input logic [2:0] mode, input int w, input int h,
                                input int xo, input int yo, input bit fresh,
                                input int n, input bit stray_starts);
        wait_idle();
        sender_calm   = ($urandom % 4) == 0;
        receiver_calm = ($urandom % 4) == 0;
        configure(mode, w, h, xo, yo);
        for (int i = 0; i < n; i++)
            push_pixel(draw_gray(), (fresh && i == 0) || (stray_starts && ($urandom % 97) == 0));
    endtask

    initial begin : stimulus
        logic [2:0] mode;
        int w, h, n, area, random_pixels;
        bit fresh;

        // predictor at its reset settings: hybrid ink, 220 x 320 at the origin
        mdl_mode   = MODE_HYB_INK;
        mdl_width  = 10'd220;
        mdl_height = 10'd320;
        mdl_xoff   = '0;
        mdl_yoff   = '0;
        pos_col    = '0;
        pos_row    = '0;
        for (int i = 0; i < LINE_WIDTH; i++) err_line[i] = '0;
        clear_carries();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: knee values of the reset mode, then a word pair in every mode code
        push_pixel(8'd0, 1'b1);
        push_pixel(8'd99, 1'b0);
        push_pixel(8'd100, 1'b0);
        push_pixel(8'd220, 1'b0);
        push_pixel(8'd221, 1'b0);
        push_pixel(8'd254, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'd128, 1'b0);
        for (int m = 0; m < 8; m++) begin
            wait_idle();
            configure(3'(m), 3, 2, 0, 0);
            push_pixel(8'd127, 1'b1);
            push_pixel(8'd128, 1'b0);
        end

        // diffusion on a sprite wider than the error line: position only
        sprite_phase(MODE_DIFFUSE, LINE_WIDTH + 1, 2, 0, 0, 1'b1, 40, 1'b0);
        // zero width, then zero height: everything dropped
        sprite_phase(MODE_BAYER8, 0, 4, 0, 0, 1'b1, 6, 1'b0);
        sprite_phase(MODE_THRESH, 4, 0, 0, 0, 1'b1, 6, 1'b0);
        // finished sprite: trailing words dropped until the next start
        sprite_phase(MODE_BAYER8, 4, 2, 10, 10, 1'b1, 13, 1'b0);
        // width shrunk under the current column mid-row
        sprite_phase(MODE_DIFFUSE, 10, 4, 0, 0, 1'b1, 7, 1'b0);
        sprite_phase(MODE_DIFFUSE, 4, 4, 0, 0, 1'b0, 10, 1'b0);
        // mode changes mid-sprite: error state survives the ordered stretch
        sprite_phase(MODE_DIFFUSE, 12, 6, 5, 5, 1'b1, 30, 1'b0);
        sprite_phase(MODE_BAYER4, 12, 6, 5, 5, 1'b0, 20, 1'b0);
        sprite_phase(MODE_DIFFUSE, 12, 6, 5, 5, 1'b0, 22, 1'b0);
        // offset and size extremes, mostly or partly off screen
        sprite_phase(MODE_THRESH, 1023, 1, -1024, 0, 1'b1, 60, 1'b0);
        sprite_phase(MODE_HYB_SOFT, 1, 1023, 1023, 1023, 1'b1, 40, 1'b0);
        sprite_phase(MODE_HYB_SOFT, 2, 1023, 0, -1024, 1'b1, 40, 1'b0);
        sprite_phase(MODE_DIFFUSE, 20, 20, SCREEN_WIDTH - 10, SCREEN_HEIGHT - 10,
                     1'b1, 150, 1'b0);

        // full-width diffusion row plus the start of the next, receiver held off part way
        wait_idle();
        configure(MODE_DIFFUSE, LINE_WIDTH, 2, $urandom_range(0, SCREEN_WIDTH - LINE_WIDTH), 0);
        sender_calm = 1'b1;
        hold_armed  = 1'b1;
        for (int i = 0; i < LINE_WIDTH + 16; i++) push_pixel(draw_gray(), i == 0);
        wait_idle();
        hold_armed  = 1'b0;

        // random phases, diffusion weighted up, mostly small sprites
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            mode = (($urandom % 10) < 4) ? MODE_DIFFUSE : 3'($urandom_range(1, 7));
            case ($urandom % 20)
                0:       w = 0;
                1:       w = 1023;
                2:       w = $urandom_range(LINE_WIDTH - 6, LINE_WIDTH + 6);
                default: w = $urandom_range(1, 24);
            endcase
            case ($urandom % 20)
                0:       h = 0;
                1:       h = 1023;
                default: h = $urandom_range(1, 8);
            endcase
            fresh = ($urandom % 4) != 0;
            area  = w * h;
            if (area == 0)
                n = $urandom_range(2, 6);
            else if (!fresh)
                n = $urandom_range(5, 40);
            else if (area <= 150)
                n = area + $urandom_range(0, 3);
            else
                n = $urandom_range(20, 150);
            sprite_phase(mode, w, h, draw_offset(SCREEN_WIDTH - 1),
                         draw_offset(SCREEN_HEIGHT - 1), fresh, n, 1'b1);
            if (area != 0) random_pixels += n;
        end

        wait_idle();
        if (mismatches == 0 && pending_writes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/msdc_pkg.sv
hdl/msdc_cfg_regs.sv
hdl/msdc_err_line.sv
hdl/msdc_dither_core.sv
hdl/masked_sprite_dither_compositor_unit.sv
tb/sv/tb_top.sv
